// File: rtl/core/lrc_pkg.sv
// Shared constants, types and helpers for the region key cache.
package lrc_pkg;

    localparam int CAPACITY     = 16;
    localparam int REGION_SHIFT = 5;
    localparam int COORD_W      = 32;
    localparam int REGION_W     = COORD_W - REGION_SHIFT;
    localparam int LOCAL_W      = REGION_SHIFT;
    localparam int KEY_W        = 2 * REGION_W;
    localparam int SLOT_W       = $clog2(CAPACITY);
    localparam int RANK_W       = SLOT_W;
    localparam int COUNT_W      = SLOT_W + 1;
    localparam int LANES        = 4;
    localparam int LANE_W       = $clog2(LANES);
    localparam int ROWS         = CAPACITY / LANES;
    localparam int ROW_W        = SLOT_W - LANE_W;
    localparam int CFG_W        = 5;
    localparam int MODE_W       = 2;
    localparam int KIND_W       = 2;
    localparam int S_TDATA_W    = 2 * COORD_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_ACCESS    = 2'd0,
        MODE_CLOSE     = 2'd1,
        MODE_CLOSE_ALL = 2'd2,
        MODE_UNUSED    = 2'd3
    } mode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_EVICT  = 2'd0,
        KIND_ACCESS = 2'd1,
        KIND_CLOSE  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        LOP_NONE   = 3'd0,
        LOP_TOUCH  = 3'd1,
        LOP_REMOVE = 3'd2,
        LOP_INSERT = 3'd3,
        LOP_CLEAR  = 3'd4
    } lop_t;

    typedef logic [KEY_W-1:0] key_t;
    typedef key_t [LANES-1:0] key_row_t;

    typedef struct packed {
        lop_t              op;
        logic [SLOT_W-1:0] slot;
    } lru_cmd_t;

    typedef struct packed {
        logic [CAPACITY-1:0] valid;
        logic [COUNT_W-1:0]  count;
        logic [SLOT_W-1:0]   oldest;
        logic [SLOT_W-1:0]   free_slot;
    } lru_stat_t;

    typedef struct packed {
        logic              wr_en;
        logic [SLOT_W-1:0] wr_slot;
        logic              rd_en;
        logic [ROW_W-1:0]  rd_row;
    } mem_req_t;

    // tdata of a result word, hit in bit 0
    typedef struct packed {
        logic [COUNT_W-1:0]  resident_count;
        logic [LOCAL_W-1:0]  local_z;
        logic [LOCAL_W-1:0]  local_x;
        logic [REGION_W-1:0] region_z;
        logic [REGION_W-1:0] region_x;
        logic [SLOT_W-1:0]   slot;
        logic                hit;
    } res_t;

    localparam int RES_W     = $bits(res_t);
    localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;
    localparam int PAD_W     = M_TDATA_W - RES_W;

    function automatic logic [COUNT_W-1:0] limit_of(input logic [CFG_W-1:0] m);
        logic [COUNT_W-1:0] l;
        begin
            if (m == '0) begin
                l = COUNT_W'(1);
            end else if (COUNT_W'(m) > COUNT_W'(CAPACITY)) begin
                l = COUNT_W'(CAPACITY);
            end else begin
                l = COUNT_W'(m);
            end
            return l;
        end
    endfunction

    function automatic logic fits_region(input logic [COORD_W-1:0] v);
        return (v[COORD_W-1:REGION_W-1] == '0) || (v[COORD_W-1:REGION_W-1] == '1);
    endfunction

endpackage

// File: rtl/core/lrc_key_mem.sv
// Key store: rows of lanes, single-lane write, one registered row read.
module lrc_key_mem
    import lrc_pkg::*;
(
    input  logic     aclk,
    input  mem_req_t req,
    input  key_t     wr_key,
    output key_row_t rd_data
);

    key_t     mem [ROWS][LANES];
    key_row_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_slot[SLOT_W-1:LANE_W]][req.wr_slot[LANE_W-1:0]] <= wr_key;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            for (int l = 0; l < LANES; l++) begin
                rd_data_reg[l] <= mem[req.rd_row][l];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/lrc_lru_state.sv
// Valid bits, recency ranks and resident count, with oldest and free slot search.
module lrc_lru_state
    import lrc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  lru_cmd_t  cmd,
    output lru_stat_t stat
);

    logic [CAPACITY-1:0] valid_reg, valid_next;
    logic [RANK_W-1:0]   rank_reg  [CAPACITY];
    logic [RANK_W-1:0]   rank_next [CAPACITY];
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [RANK_W-1:0]   r_sel;
    logic [SLOT_W-1:0]   oldest, free_slot;

    always_comb begin
        oldest    = '0;
        free_slot = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (valid_reg[i] && rank_reg[i] == '0) begin
                oldest = SLOT_W'(i);
            end
            if (!valid_reg[i]) begin
                free_slot = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        valid_next = valid_reg;
        count_next = count_reg;
        r_sel      = rank_reg[cmd.slot];
        for (int i = 0; i < CAPACITY; i++) begin
            rank_next[i] = rank_reg[i];
        end
        case (cmd.op)
            LOP_TOUCH: begin
                for (int i = 0; i < CAPACITY; i++) begin
                    if (valid_reg[i] && rank_reg[i] > r_sel) begin
                        rank_next[i] = rank_reg[i] - RANK_W'(1);
                    end
                end
                rank_next[cmd.slot] = RANK_W'(count_reg - COUNT_W'(1));
            end
            LOP_REMOVE: begin
                for (int i = 0; i < CAPACITY; i++) begin
                    if (valid_reg[i] && rank_reg[i] > r_sel) begin
                        rank_next[i] = rank_reg[i] - RANK_W'(1);
                    end
                end
                valid_next[cmd.slot] = 1'b0;
                rank_next[cmd.slot]  = '0;
                count_next           = count_reg - COUNT_W'(1);
            end
            LOP_INSERT: begin
                valid_next[cmd.slot] = 1'b1;
                rank_next[cmd.slot]  = RANK_W'(count_reg);
                count_next           = count_reg + COUNT_W'(1);
            end
            LOP_CLEAR: begin
                valid_next = '0;
                count_next = '0;
                for (int i = 0; i < CAPACITY; i++) begin
                    rank_next[i] = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < CAPACITY; i++) begin
                rank_reg[i] <= '0;
            end
        end else begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            for (int i = 0; i < CAPACITY; i++) begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    assign stat.valid     = valid_reg;
    assign stat.count     = count_reg;
    assign stat.oldest    = oldest;
    assign stat.free_slot = free_slot;

endmodule

// File: rtl/core/lru_region_key_cache.sv
// Top level: LRU region key cache with key memory scan and result register.
//
//  channel | ports           | word
//  --------+-----------------+---------------------------------------------
//  in      | s_tvalid/tready | tuser mode; tdata x_coord, z_coord
//  out     | m_tvalid/tready | tuser kind; tdata result fields; tlast
//  config  | cfg_wr_en       | cfg_wr_data max_entries, written at once
//
//  Lookup reads the key memory one row of four keys a cycle: an access or close
//  scans every row, then ST_DECIDE puts its word in the output register; a miss
//  first reads and reports each eviction, then inserts. Close-all emits from
//  ST_CLR, mode 3 none. Input resumes in ST_IDLE. Lowering the limit removes one
//  oldest entry a cycle with s_tready low. Reset clears valid bits, ranks and
//  count at once. One output register: a word may wait there while input is taken.
module lru_region_key_cache
    import lrc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // x_coord, z_coord
    input  logic [MODE_W-1:0]    s_tuser,   // mode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // hit, slot, region_x, region_z, local_x, local_z, resident_count, zero pad
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [KIND_W-1:0]    m_tuser,   // kind
    output logic                 m_tlast,
    input  logic                 cfg_wr_en,
    input  logic [CFG_W-1:0]     cfg_wr_data
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SCAN   = 7'b0000010,
        ST_DECIDE = 7'b0000100,
        ST_EV_RD  = 7'b0001000,
        ST_EV_OUT = 7'b0010000,
        ST_INSERT = 7'b0100000,
        ST_CLR    = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    mode_t               mode_reg, mode_next;
    key_t                key_reg, key_next;
    logic [LOCAL_W-1:0]  lx_reg, lx_next, lz_reg, lz_next;
    logic                fits_reg, fits_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic                hit_reg, hit_next;
    logic [SLOT_W-1:0]   hit_slot_reg, hit_slot_next;
    logic [SLOT_W-1:0]   ev_slot_reg, ev_slot_next;
    logic [CFG_W-1:0]    max_reg;
    logic                out_valid_reg;
    res_t                out_res_reg;
    kind_t               out_kind_reg;
    logic                out_last_reg;

    logic [COORD_W-1:0]  in_x, in_z;
    logic [COUNT_W-1:0]  limit;
    logic [COUNT_W-1:0]  cnt_dec;
    logic                trim;
    logic                in_acc;
    logic                out_free;
    logic                emit;
    res_t                emit_res;
    kind_t               emit_kind;
    logic                emit_last;
    lru_cmd_t            cmd;
    lru_stat_t           stat;
    mem_req_t            mreq;
    key_t                wr_key;
    key_row_t            rd_data;
    key_t                ev_key;

    function automatic res_t make_res(input logic hit, input logic [SLOT_W-1:0] slot,
                                      input key_t key, input logic [LOCAL_W-1:0] lx,
                                      input logic [LOCAL_W-1:0] lz,
                                      input logic [COUNT_W-1:0] cnt);
        res_t r;
        begin
            r.hit            = hit;
            r.slot           = slot;
            r.region_x       = key[KEY_W-1:REGION_W];
            r.region_z       = key[REGION_W-1:0];
            r.local_x        = lx;
            r.local_z        = lz;
            r.resident_count = cnt;
            return r;
        end
    endfunction

    lrc_key_mem u_key_mem (
        .aclk    (aclk),
        .req     (mreq),
        .wr_key  (wr_key),
        .rd_data (rd_data)
    );

    lrc_lru_state u_lru_state (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat)
    );

    assign in_x     = s_tdata[COORD_W-1:0];
    assign in_z     = s_tdata[S_TDATA_W-1:COORD_W];
    assign limit    = limit_of(max_reg);
    assign cnt_dec  = stat.count - COUNT_W'(1);
    assign trim     = stat.count > limit;
    assign s_tready = (state_reg == ST_IDLE) && !trim && !cfg_wr_en;
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign ev_key   = rd_data[ev_slot_reg[LANE_W-1:0]];
    assign wr_key   = key_reg;

    always_comb begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        key_next      = key_reg;
        lx_next       = lx_reg;
        lz_next       = lz_reg;
        fits_next     = fits_reg;
        row_next      = row_reg;
        hit_next      = hit_reg;
        hit_slot_next = hit_slot_reg;
        ev_slot_next  = ev_slot_reg;
        cmd.op        = LOP_NONE;
        cmd.slot      = '0;
        mreq.wr_en    = 1'b0;
        mreq.wr_slot  = stat.free_slot;
        mreq.rd_en    = 1'b0;
        mreq.rd_row   = '0;
        emit          = 1'b0;
        emit_kind     = KIND_ACCESS;
        emit_last     = 1'b1;
        emit_res      = make_res(1'b0, '0, key_reg, lx_reg, lz_reg, stat.count);

        case (state_reg)
            ST_IDLE: begin
                if (trim) begin
                    cmd.op   = LOP_REMOVE;
                    cmd.slot = stat.oldest;
                end else if (in_acc) begin
                    mode_next     = mode_t'(s_tuser);
                    lx_next       = in_x[LOCAL_W-1:0];
                    lz_next       = in_z[LOCAL_W-1:0];
                    row_next      = '0;
                    hit_next      = 1'b0;
                    hit_slot_next = '0;
                    case (mode_t'(s_tuser))
                        MODE_ACCESS: begin
                            key_next    = {in_x[COORD_W-1:REGION_SHIFT],
                                           in_z[COORD_W-1:REGION_SHIFT]};
                            fits_next   = 1'b1;
                            mreq.rd_en  = 1'b1;
                            state_next  = ST_SCAN;
                        end
                        MODE_CLOSE: begin
                            key_next    = {in_x[REGION_W-1:0], in_z[REGION_W-1:0]};
                            fits_next   = fits_region(in_x) && fits_region(in_z);
                            mreq.rd_en  = 1'b1;
                            state_next  = ST_SCAN;
                        end
                        MODE_CLOSE_ALL: begin
                            state_next = ST_CLR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                for (int l = 0; l < LANES; l++) begin
                    if (stat.valid[{row_reg, LANE_W'(l)}] && fits_reg &&
                        rd_data[l] == key_reg) begin
                        hit_next      = 1'b1;
                        hit_slot_next = {row_reg, LANE_W'(l)};
                    end
                end
                if (row_reg == ROW_W'(ROWS - 1)) begin
                    state_next = ST_DECIDE;
                end else begin
                    mreq.rd_en  = 1'b1;
                    mreq.rd_row = row_reg + ROW_W'(1);
                    row_next    = row_reg + ROW_W'(1);
                end
            end
            ST_DECIDE: begin
                if (mode_reg == MODE_ACCESS) begin
                    if (hit_reg) begin
                        if (out_free) begin
                            emit       = 1'b1;
                            emit_res   = make_res(1'b1, hit_slot_reg, key_reg, lx_reg,
                                                  lz_reg, stat.count);
                            cmd.op     = LOP_TOUCH;
                            cmd.slot   = hit_slot_reg;
                            state_next = ST_IDLE;
                        end
                    end else if (stat.count >= limit) begin
                        state_next = ST_EV_RD;
                    end else begin
                        state_next = ST_INSERT;
                    end
                end else if (out_free) begin
                    emit       = 1'b1;
                    emit_kind  = KIND_CLOSE;
                    emit_res   = make_res(hit_reg, hit_reg ? hit_slot_reg : '0, key_reg,
                                          '0, '0, hit_reg ? cnt_dec : stat.count);
                    if (hit_reg) begin
                        cmd.op   = LOP_REMOVE;
                        cmd.slot = hit_slot_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_EV_RD: begin
                ev_slot_next = stat.oldest;
                mreq.rd_en   = 1'b1;
                mreq.rd_row  = stat.oldest[SLOT_W-1:LANE_W];
                state_next   = ST_EV_OUT;
            end
            ST_EV_OUT: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_kind = KIND_EVICT;
                    emit_last = 1'b0;
                    emit_res  = make_res(1'b0, ev_slot_reg, ev_key, '0, '0, cnt_dec);
                    cmd.op    = LOP_REMOVE;
                    cmd.slot  = ev_slot_reg;
                    if (cnt_dec >= limit) begin
                        state_next = ST_EV_RD;
                    end else begin
                        state_next = ST_INSERT;
                    end
                end
            end
            ST_INSERT: begin
                if (out_free) begin
                    mreq.wr_en = 1'b1;
                    cmd.op     = LOP_INSERT;
                    cmd.slot   = stat.free_slot;
                    emit       = 1'b1;
                    emit_res   = make_res(1'b0, stat.free_slot, key_reg, lx_reg, lz_reg,
                                          stat.count + COUNT_W'(1));
                    state_next = ST_IDLE;
                end
            end
            ST_CLR: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_kind  = KIND_CLOSE;
                    emit_res   = make_res(stat.count != '0, '0, '0, '0, '0, '0);
                    cmd.op     = LOP_CLEAR;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            max_reg       <= CFG_W'(CAPACITY);
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                max_reg <= cfg_wr_data;
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg     <= mode_next;
        key_reg      <= key_next;
        lx_reg       <= lx_next;
        lz_reg       <= lz_next;
        fits_reg     <= fits_next;
        row_reg      <= row_next;
        hit_reg      <= hit_next;
        hit_slot_reg <= hit_slot_next;
        ev_slot_reg  <= ev_slot_next;
        if (emit) begin
            out_res_reg  <= emit_res;
            out_kind_reg <= emit_kind;
            out_last_reg <= emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_res_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: rtl/core/lrc_checker.sv
// Port-level checks for the region key cache, bound to the top level.
module lrc_checker
    import lrc_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [KIND_W-1:0]    m_tuser,
    input logic                 m_tlast
);

    // no result word straight out of reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result word valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
        $stable(m_tlast))
        else $error("stalled result word changed");

    // eviction reports are never final and never hits
    a_evict_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_EVICT |-> !m_tlast && !m_tdata[0])
        else $error("malformed eviction report");

    // input is held off while an item still has results to come
    a_no_take_mid_item: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input taken while an item is unfinished");

endmodule

bind lru_region_key_cache lrc_checker u_lrc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// File: sim/tb_top.sv
// Self-checking testbench for the LRU region key cache: directed table, then random traffic.
module tb_top
    import lrc_pkg::*;
();

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_WORDS = 10;
    localparam int POOL_SIZE   = 24;

    typedef struct {
        kind_t               kind;
        logic                hit;
        logic [SLOT_W-1:0]   slot;
        logic [REGION_W-1:0] rx;
        logic [REGION_W-1:0] rz;
        logic [LOCAL_W-1:0]  lx;
        logic [LOCAL_W-1:0]  lz;
        logic [COUNT_W-1:0]  cnt;
        logic                last;
    } cache_word_t;

    typedef struct {
        bit                 set_limit;
        logic [CFG_W-1:0]   limit_val;
        mode_t              mode;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] z;
        bit                 typed;
        cache_word_t        want;
    } stim_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [MODE_W-1:0]    s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]    m_tuser;
    logic                 m_tlast;
    logic                 cfg_wr_en;
    logic [CFG_W-1:0]     cfg_wr_data;

    // cache image kept by the predictor
    key_t             img_key  [CAPACITY];
    bit               img_vld  [CAPACITY];
    int               img_rank [CAPACITY];
    int               img_count;
    logic [CFG_W-1:0] img_limit;

    cache_word_t         pending_cache_words[$];
    stim_row_t           directed_rows[$];
    logic [REGION_W-1:0] pool_rx[POOL_SIZE];
    logic [REGION_W-1:0] pool_rz[POOL_SIZE];

    int err_cnt;
    int burst_left;
    bit hold_req;

    lru_region_key_cache DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever begin
            #1 aclk = ~aclk;
        end
    end

    initial begin
        int cyc;
        cyc = 0;
        while (cyc < CYCLE_LIMIT) begin
            @(posedge aclk);
            cyc++;
        end
        $display("** lru_region_key_cache: FAILED **");
        $finish;
    end

    // ---------------- predictor ----------------

    function automatic int eff_limit();
        if (img_limit == 0) begin
            return 1;
        end
        if (int'(img_limit) > CAPACITY) begin
            return CAPACITY;
        end
        return int'(img_limit);
    endfunction

    function automatic int oldest_slot();
        for (int i = 0; i < CAPACITY; i++) begin
            if (img_vld[i] && img_rank[i] == 0) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic int find_region(key_t key);
        for (int i = 0; i < CAPACITY; i++) begin
            if (img_vld[i] && img_key[i] == key) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic void drop_entry(int s);
        int r;
        r = img_rank[s];
        img_vld[s]  = 1'b0;
        img_rank[s] = 0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (img_vld[i] && img_rank[i] > r) begin
                img_rank[i]--;
            end
        end
        if (img_count > 0) begin
            img_count--;
        end
    endfunction

    function automatic void note_word(kind_t k, logic h, int s, key_t key,
                                      logic [LOCAL_W-1:0] lx, logic [LOCAL_W-1:0] lz,
                                      logic last);
        cache_word_t w;
        w.kind = k;
        w.hit  = h;
        w.slot = SLOT_W'(s);
        w.rx   = key[KEY_W-1:REGION_W];
        w.rz   = key[REGION_W-1:0];
        w.lx   = lx;
        w.lz   = lz;
        w.cnt  = COUNT_W'(img_count);
        w.last = last;
        pending_cache_words = {pending_cache_words, w};
    endfunction

    function automatic void apply_limit(logic [CFG_W-1:0] v);
        int o;
        img_limit = v;
        while (img_count > eff_limit()) begin
            o = oldest_slot();
            if (o < 0) begin
                break;
            end
            drop_entry(o);
        end
    endfunction

    function automatic void predict_cache_results(mode_t mode, logic [COORD_W-1:0] x,
                                                  logic [COORD_W-1:0] z);
        key_t key;
        key_t old_key;
        int   s;
        int   o;
        int   r;
        bit   fits;
        case (mode)
            MODE_ACCESS: begin
                key = {x[COORD_W-1:REGION_SHIFT], z[COORD_W-1:REGION_SHIFT]};
                s = find_region(key);
                if (s >= 0) begin
                    r = img_rank[s];
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (img_vld[i] && img_rank[i] > r) begin
                            img_rank[i]--;
                        end
                    end
                    img_rank[s] = img_count - 1;
                    note_word(KIND_ACCESS, 1'b1, s, key, x[LOCAL_W-1:0], z[LOCAL_W-1:0], 1'b1);
                end else begin
                    while (img_count >= eff_limit()) begin
                        o = oldest_slot();
                        if (o < 0) begin
                            break;
                        end
                        old_key = img_key[o];
                        drop_entry(o);
                        note_word(KIND_EVICT, 1'b0, o, old_key, '0, '0, 1'b0);
                    end
                    s = 0;
                    for (int i = CAPACITY - 1; i >= 0; i--) begin
                        if (!img_vld[i]) begin
                            s = i;
                        end
                    end
                    img_key[s]  = key;
                    img_vld[s]  = 1'b1;
                    img_rank[s] = img_count;
                    img_count++;
                    note_word(KIND_ACCESS, 1'b0, s, key, x[LOCAL_W-1:0], z[LOCAL_W-1:0], 1'b1);
                end
            end
            MODE_CLOSE: begin
                key  = {x[REGION_W-1:0], z[REGION_W-1:0]};
                fits = (x[COORD_W-1:REGION_W] == {REGION_SHIFT{x[REGION_W-1]}}) &&
                       (z[COORD_W-1:REGION_W] == {REGION_SHIFT{z[REGION_W-1]}});
                s = fits ? find_region(key) : -1;
                if (s >= 0) begin
                    drop_entry(s);
                    note_word(KIND_CLOSE, 1'b1, s, key, '0, '0, 1'b1);
                end else begin
                    note_word(KIND_CLOSE, 1'b0, 0, key, '0, '0, 1'b1);
                end
            end
            MODE_CLOSE_ALL: begin
                fits = (img_count > 0);
                for (int i = 0; i < CAPACITY; i++) begin
                    img_vld[i]  = 1'b0;
                    img_rank[i] = 0;
                end
                img_count = 0;
                note_word(KIND_CLOSE, fits, 0, '0, '0, '0, 1'b1);
            end
            default: begin
            end
        endcase
    endfunction

    // ---------------- directed table ----------------

    function automatic void add_row(mode_t mode, logic [COORD_W-1:0] x,
                                    logic [COORD_W-1:0] z);
        stim_row_t row;
        row.set_limit = 1'b0;
        row.limit_val = '0;
        row.mode      = mode;
        row.x         = x;
        row.z         = z;
        row.typed     = 1'b0;
        row.want      = '{KIND_EVICT, 1'b0, '0, '0, '0, '0, '0, '0, 1'b0};
        directed_rows = {directed_rows, row};
    endfunction

    function automatic void add_typed(mode_t mode, logic [COORD_W-1:0] x,
                                      logic [COORD_W-1:0] z, kind_t k, logic h,
                                      int s, logic [REGION_W-1:0] rx,
                                      logic [REGION_W-1:0] rz, int lx, int lz, int cnt);
        add_row(mode, x, z);
        directed_rows[$].typed = 1'b1;
        directed_rows[$].want  = '{k, h, SLOT_W'(s), rx, rz, LOCAL_W'(lx), LOCAL_W'(lz),
                                   COUNT_W'(cnt), 1'b1};
    endfunction

    function automatic void add_limit(logic [CFG_W-1:0] v);
        add_row(MODE_ACCESS, '0, '0);
        directed_rows[$].set_limit = 1'b1;
        directed_rows[$].limit_val = v;
    endfunction

    function automatic void build_table();
        add_typed(MODE_ACCESS, 32'h0, 32'h0, KIND_ACCESS, 1'b0, 0, '0, '0, 0, 0, 1);
        add_typed(MODE_ACCESS, 32'hFFFFFFFF, 32'hFFFFFFFF, KIND_ACCESS, 1'b0, 1,
                  27'h7FFFFFF, 27'h7FFFFFF, 31, 31, 2);
        add_typed(MODE_ACCESS, 32'h7FFFFFFF, 32'h80000000, KIND_ACCESS, 1'b0, 2,
                  27'h3FFFFFF, 27'h4000000, 31, 0, 3);
        add_row(MODE_ACCESS, 32'd5, 32'd37);
        add_row(MODE_ACCESS, 32'd31, 32'd2);
        add_row(MODE_ACCESS, -32'sd33, 32'd0);
        add_typed(MODE_CLOSE, 32'd0, 32'd1, KIND_CLOSE, 1'b1, 3, '0, 27'd1, 0, 0, 4);
        add_typed(MODE_CLOSE, 32'd0, 32'd1, KIND_CLOSE, 1'b0, 0, '0, 27'd1, 0, 0, 4);
        // region coordinates outside the 27-bit range never match
        add_typed(MODE_CLOSE, 32'h04000000, 32'hFBFFFFFF, KIND_CLOSE, 1'b0, 0,
                  27'h4000000, 27'h3FFFFFF, 0, 0, 4);
        add_row(MODE_CLOSE, 32'hFFFFFFFF, 32'hFFFFFFFF);
        add_row(MODE_UNUSED, 32'hDEADBEEF, 32'h0BADF00D);
        add_row(MODE_ACCESS, 32'd3, 32'd40);
        add_limit(5'd2);
        add_row(MODE_ACCESS, 32'd1000, 32'd1000);
        add_row(MODE_ACCESS, 32'd1001, 32'd999);
        add_row(MODE_ACCESS, -32'sd5000, 32'd7);
        add_limit(5'd0);
        add_row(MODE_ACCESS, 32'd64, 32'd64);
        add_typed(MODE_CLOSE_ALL, 32'hFFFFFFFF, 32'hFFFFFFFF, KIND_CLOSE, 1'b1, 0,
                  '0, '0, 0, 0, 0);
        add_typed(MODE_CLOSE_ALL, 32'h0, 32'h0, KIND_CLOSE, 1'b0, 0, '0, '0, 0, 0, 0);
        add_limit(5'd31);
        add_row(MODE_ACCESS, 32'h12345678, 32'h87654321);
        add_row(MODE_CLOSE, 32'h0091A2B3, 32'hFC3B2A19);
        add_row(MODE_UNUSED, 32'h0, 32'hFFFFFFFF);
    endfunction

    // ---------------- driving ----------------

    task automatic send_word(mode_t mode, logic [COORD_W-1:0] x, logic [COORD_W-1:0] z);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {z, x};
        do begin
            @(posedge aclk);
        end while (!s_tready);
        predict_cache_results(mode, x, z);
    endtask

    task automatic pace_sender();
        burst_left--;
        if (burst_left <= 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge aclk);
            burst_left = $urandom_range(1, 12);
        end
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_cache_words.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_limit(logic [CFG_W-1:0] v);
        drain_results();
        // mode 3 words leave nothing to wait for
        repeat (12) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        apply_limit(v);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        burst_left = $urandom_range(1, 12);
    endtask

    initial begin
        logic [CFG_W-1:0]    limits[8];
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  z;
        logic [REGION_W-1:0] rv;
        mode_t               md;
        int                  n_sent;
        int                  pick;
        int                  idx;

        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = MODE_ACCESS;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        err_cnt     = 0;
        hold_req    = 1'b0;
        burst_left  = 4;
        limits      = '{5'd3, 5'd1, 5'd16, 5'd0, 5'd31, 5'd5, 5'd2, 5'd8};

        for (int i = 0; i < CAPACITY; i++) begin
            img_key[i]  = '0;
            img_vld[i]  = 1'b0;
            img_rank[i] = 0;
        end
        img_count = 0;
        img_limit = 5'd16;

        build_table();
        for (int i = 0; i < POOL_SIZE; i++) begin
            if (i < 4) begin
                rv = (i == 0) ? 27'h3FFFFFF : (i == 1) ? 27'h4000000 :
                     (i == 2) ? 27'h0 : 27'h7FFFFFF;
                pool_rx[i] = rv;
                pool_rz[i] = ~rv;
            end else if (i < 14) begin
                pool_rx[i] = REGION_W'($urandom_range(0, 3)) - 27'd1;
                pool_rz[i] = REGION_W'($urandom_range(0, 3)) - 27'd1;
            end else begin
                pool_rx[i] = REGION_W'($urandom);
                pool_rz[i] = REGION_W'($urandom);
            end
        end

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].set_limit) begin
                write_limit(directed_rows[i].limit_val);
            end else begin
                send_word(directed_rows[i].mode, directed_rows[i].x, directed_rows[i].z);
                if (directed_rows[i].typed) begin
                    pending_cache_words[pending_cache_words.size() - 1] = directed_rows[i].want;
                end
                pace_sender();
            end
        end

        for (int ph = 0; ph < 8; ph++) begin
            write_limit(limits[ph]);
            if (ph == 2) begin
                // long receiver hold-off against an unbroken burst
                hold_req   = 1'b1;
                burst_left = 24;
            end
            n_sent = 0;
            while (n_sent < PHASE_WORDS) begin
                pick = $urandom_range(0, 99);
                idx  = $urandom_range(0, POOL_SIZE - 1);
                if (pick < 62) begin
                    md = MODE_ACCESS;
                    x  = {pool_rx[idx], LOCAL_W'($urandom)};
                    z  = {pool_rz[idx], LOCAL_W'($urandom)};
                end else if (pick < 70) begin
                    md = MODE_ACCESS;
                    x  = $urandom;
                    z  = $urandom;
                end else if (pick < 84) begin
                    md = MODE_CLOSE;
                    x  = {{REGION_SHIFT{pool_rx[idx][REGION_W-1]}}, pool_rx[idx]};
                    z  = {{REGION_SHIFT{pool_rz[idx][REGION_W-1]}}, pool_rz[idx]};
                end else if (pick < 90) begin
                    md = MODE_CLOSE;
                    x  = $urandom;
                    z  = $urandom;
                end else if (pick < 94) begin
                    md = MODE_CLOSE_ALL;
                    x  = $urandom;
                    z  = $urandom;
                end else begin
                    md = MODE_UNUSED;
                    x  = $urandom;
                    z  = $urandom;
                end
                send_word(md, x, z);
                if (md != MODE_UNUSED) begin
                    n_sent++;
                end
                if (ph == 4 && n_sent == 6 && md != MODE_UNUSED) begin
                    drain_results();
                end
                pace_sender();
            end
        end

        drain_results();
        repeat (40) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("** lru_region_key_cache: PASSED **");
        end else begin
            $display("** lru_region_key_cache: FAILED **");
        end
        $finish;
    end

    // receiver: changing stall pattern plus one long hold-off
    initial begin
        int          style;
        int          span;
        logic [7:0]  pat;
        m_tready = 1'b0;
        style    = 0;
        span     = 0;
        pat      = 8'hA5;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++) begin
                    @(negedge aclk);
                end
            end
            if (span == 0) begin
                style = $urandom_range(0, 3);
                span  = $urandom_range(16, 96);
                pat   = 8'($urandom);
            end
            span--;
            case (style)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= pat[span % 8];
            endcase
        end
    end

    // ---------------- checking ----------------

    task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", fname, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge aclk) begin
        res_t        got;
        cache_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = res_t'(m_tdata[RES_W-1:0]);
            if (pending_cache_words.size() == 0) begin
                $error("unexpected result word: kind %0h tdata %0h", m_tuser, m_tdata);
                err_cnt++;
            end else begin
                want = pending_cache_words[0];
                pending_cache_words.delete(0);
                check_field("kind", 32'(want.kind), 32'(m_tuser));
                check_field("hit", 32'(want.hit), 32'(got.hit));
                check_field("slot", 32'(want.slot), 32'(got.slot));
                check_field("region_x", 32'(want.rx), 32'(got.region_x));
                check_field("region_z", 32'(want.rz), 32'(got.region_z));
                check_field("local_x", 32'(want.lx), 32'(got.local_x));
                check_field("local_z", 32'(want.lz), 32'(got.local_z));
                check_field("resident_count", 32'(want.cnt), 32'(got.resident_count));
                check_field("last", 32'(want.last), 32'(m_tlast));
            end
        end
    end

endmodule

// File: lru_region_key_cache.f
rtl/core/lrc_pkg.sv
rtl/core/lrc_key_mem.sv
rtl/core/lrc_lru_state.sv
rtl/core/lru_region_key_cache.sv
rtl/core/lrc_checker.sv
sim/tb_top.sv
